// ===== src/sem_pkg.sv =====
// Shared types and constants for the RGB Sobel edge magnitude block.
// Depends on nothing; all other files but sem_checker take names from here.
`timescale 1ns / 1ps

package sem_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  localparam int unsigned CHAN_BITS       = 8;
  localparam int unsigned PIX_BITS        = 3 * CHAN_BITS;
  localparam int unsigned CFG_WIDTH_BITS  = 11;
  localparam int unsigned CFG_HEIGHT_BITS = 13;
  localparam int unsigned CFG_DATA_BITS   = 13;
  localparam int unsigned CFG_INDEX_BITS  = 1;
  localparam int unsigned RESET_WIDTH     = 640;
  localparam int unsigned RESET_HEIGHT    = 480;

  // Gradient, squared magnitude and root search widths
  localparam int unsigned GRAD_BITS  = 12;
  localparam int unsigned PWR_BITS   = 21;
  localparam int unsigned ROOT_STEPS = 8;
  localparam int unsigned STEP_BITS  = 3;
  localparam int unsigned MAG_CAP    = 255;
  localparam int unsigned PWR_CAP    = MAG_CAP * (MAG_CAP + 1);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_CAP,
    ST_GRAD,
    ST_PWR,
    ST_ROOT,
    ST_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic                 accept;
    logic                 rd_en;
    logic [1:0]           rd_col;
    logic                 cap_en;
    logic [1:0]           cap_col;
    logic                 grad_en;
    logic                 pwr_en;
    logic                 root_en;
    logic [STEP_BITS-1:0] root_bit;
    logic                 emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic lead_full;
    logic out_free;
  } sts_t;

endpackage

// ===== src/sem_if.sv =====
// Handshake channel interfaces: pixel input, edge output, register writes.
// Depends on sem_pkg for field widths.
`timescale 1ns / 1ps

interface sem_pix_if;
  logic                           valid;
  logic                           ready;
  logic [sem_pkg::CHAN_BITS-1:0]  red;
  logic [sem_pkg::CHAN_BITS-1:0]  green;
  logic [sem_pkg::CHAN_BITS-1:0]  blue;
  logic                           drain;
  modport source (output valid, red, green, blue, drain, input ready);
  modport sink   (input valid, red, green, blue, drain, output ready);
endinterface

interface sem_edge_if;
  logic                           valid;
  logic                           ready;
  logic [sem_pkg::CHAN_BITS-1:0]  edge_red;
  logic [sem_pkg::CHAN_BITS-1:0]  edge_green;
  logic [sem_pkg::CHAN_BITS-1:0]  edge_blue;
  logic                           last_pixel;
  modport source (output valid, edge_red, edge_green, edge_blue, last_pixel, input ready);
  modport sink   (input valid, edge_red, edge_green, edge_blue, last_pixel, output ready);
endinterface

interface sem_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [sem_pkg::CFG_INDEX_BITS-1:0]  index;
  logic [sem_pkg::CFG_DATA_BITS-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/sobel_edge_magnitude_rgb.sv =====
// RGB Sobel edge magnitude over a 3x3 window, zero outside the frame.
// A beat inside the first width+1 of a frame is only stored and gives no result.
// Other beats pass through 3 ring reads, capture, gradient, power, 8 root search
// steps and the output register; the next beat is taken only after the result
// has entered the output register, which waits for space.
// Reset clears control and sets the frame size to 640x480; the ring needs no clearing.
// Depends on sem_pkg, sem_if, sem_ctrl and sem_datapath.
`timescale 1ns / 1ps

module sobel_edge_magnitude_rgb #(
  parameter int unsigned MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sem_pix_if.sink      pix_i,
  sem_edge_if.source   edge_o,
  sem_cfg_if.sink      cfg_i
);

  sem_pkg::cmd_t cmd;
  sem_pkg::sts_t sts;

  // Register writes are always taken
  assign cfg_i.ready = 1'b1;

  sem_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix_i.valid),
    .in_ready_o (pix_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sem_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .red_i        (pix_i.red),
    .green_i      (pix_i.green),
    .blue_i       (pix_i.blue),
    .drain_i      (pix_i.drain),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .out_valid_o  (edge_o.valid),
    .out_ready_i  (edge_o.ready),
    .edge_red_o   (edge_o.edge_red),
    .edge_green_o (edge_o.edge_green),
    .edge_blue_o  (edge_o.edge_blue),
    .last_pixel_o (edge_o.last_pixel)
  );

endmodule

// ===== src/sem_ctrl.sv =====
// Sequencer for the Sobel block: steps each item through reads, capture, gradient,
// power, root search and output. Depends on sem_pkg for states, commands and status.
`timescale 1ns / 1ps

module sem_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sem_pkg::sts_t sts_i,
  output sem_pkg::cmd_t cmd_o
);

  sem_pkg::state_e state_q, state_d;
  logic [sem_pkg::STEP_BITS-1:0] step_q, step_d;

  // Hold state and root step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sem_pkg::ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      sem_pkg::ST_IDLE: begin
        if (in_valid_i && sts_i.lead_full) state_d = sem_pkg::ST_RD0;
      end
      sem_pkg::ST_RD0:  state_d = sem_pkg::ST_RD1;
      sem_pkg::ST_RD1:  state_d = sem_pkg::ST_RD2;
      sem_pkg::ST_RD2:  state_d = sem_pkg::ST_CAP;
      sem_pkg::ST_CAP:  state_d = sem_pkg::ST_GRAD;
      sem_pkg::ST_GRAD: state_d = sem_pkg::ST_PWR;
      sem_pkg::ST_PWR: begin
        state_d = sem_pkg::ST_ROOT;
        step_d  = sem_pkg::STEP_BITS'(sem_pkg::ROOT_STEPS - 1);
      end
      sem_pkg::ST_ROOT: begin
        if (step_q == '0) state_d = sem_pkg::ST_DONE;
        else step_d = step_q - 1'b1;
      end
      sem_pkg::ST_DONE: begin
        if (sts_i.out_free) state_d = sem_pkg::ST_IDLE;
      end
      default: state_d = sem_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      sem_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      sem_pkg::ST_RD0: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_col = 2'd0;
      end
      sem_pkg::ST_RD1: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_col  = 2'd1;
        cmd_o.cap_en  = 1'b1;
        cmd_o.cap_col = 2'd0;
      end
      sem_pkg::ST_RD2: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_col  = 2'd2;
        cmd_o.cap_en  = 1'b1;
        cmd_o.cap_col = 2'd1;
      end
      sem_pkg::ST_CAP: begin
        cmd_o.cap_en  = 1'b1;
        cmd_o.cap_col = 2'd2;
      end
      sem_pkg::ST_GRAD: cmd_o.grad_en = 1'b1;
      sem_pkg::ST_PWR:  cmd_o.pwr_en  = 1'b1;
      sem_pkg::ST_ROOT: begin
        cmd_o.root_en  = 1'b1;
        cmd_o.root_bit = step_q;
      end
      sem_pkg::ST_DONE: cmd_o.emit = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== src/sem_datapath.sv =====
// Datapath for the Sobel block: register file, pixel ring memory, window,
// gradients, squared magnitude, bitwise root search and output register.
// Depends on sem_pkg for widths, register codes, commands and status.
`timescale 1ns / 1ps

module sem_datapath #(
  parameter int unsigned MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sem_pkg::cmd_t                       cmd_i,
  output sem_pkg::sts_t                       sts_o,
  input  logic [sem_pkg::CHAN_BITS-1:0]       red_i,
  input  logic [sem_pkg::CHAN_BITS-1:0]       green_i,
  input  logic [sem_pkg::CHAN_BITS-1:0]       blue_i,
  input  logic                                drain_i,
  input  logic                                cfg_valid_i,
  input  logic [sem_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic [sem_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [sem_pkg::CHAN_BITS-1:0]       edge_red_o,
  output logic [sem_pkg::CHAN_BITS-1:0]       edge_green_o,
  output logic [sem_pkg::CHAN_BITS-1:0]       edge_blue_o,
  output logic                                last_pixel_o
);

  localparam int unsigned RING = 2 * MAX_WIDTH + 3;
  localparam int unsigned AW   = $clog2(RING);
  localparam int unsigned SW   = AW + 2;
  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CB   = sem_pkg::CHAN_BITS;
  localparam int unsigned PB   = sem_pkg::PIX_BITS;
  localparam int unsigned GB   = sem_pkg::GRAD_BITS;
  localparam int unsigned QB   = sem_pkg::PWR_BITS;

  // Configuration registers
  logic [sem_pkg::CFG_WIDTH_BITS-1:0]  width_q;
  logic [sem_pkg::CFG_HEIGHT_BITS-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= sem_pkg::CFG_WIDTH_BITS'(sem_pkg::RESET_WIDTH);
      height_q <= sem_pkg::CFG_HEIGHT_BITS'(sem_pkg::RESET_HEIGHT);
    end else if (cfg_valid_i) begin
      case (sem_pkg::reg_idx_e'(cfg_index_i))
        sem_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data_i[sem_pkg::CFG_WIDTH_BITS-1:0];
        sem_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp frame size to 1..max
  logic [31:0]   wid32, hgt32;
  logic [WW-1:0] w;
  logic [HW-1:0] h;

  always_comb begin
    wid32 = 32'(width_q);
    hgt32 = 32'(height_q);
    if (wid32 == 32'd0)          w = WW'(1);
    else if (wid32 > MAX_WIDTH)  w = WW'(MAX_WIDTH);
    else                         w = WW'(wid32);
    if (hgt32 == 32'd0)          h = HW'(1);
    else if (hgt32 > MAX_HEIGHT) h = HW'(MAX_HEIGHT);
    else                         h = HW'(hgt32);
  end

  // Write pointer, lead counter and raster position
  logic [AW-1:0] wp_q, wp_d;
  logic [WW:0]   lead_q;
  logic [WW-1:0] col_q;
  logic [HW-1:0] row_q;
  logic [PB-1:0] pix;
  logic          last;

  assign pix  = drain_i ? '0 : {blue_i, green_i, red_i};
  assign wp_d = (wp_q == AW'(RING - 1)) ? '0 : wp_q + 1'b1;
  assign last = ((HW + 1)'(row_q) + 1'b1 >= (HW + 1)'(h)) &&
                ((WW + 1)'(col_q) + 1'b1 >= (WW + 1)'(w));

  assign sts_o.lead_full = lead_q >= (WW + 1)'(w) + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      lead_q <= '0;
      col_q  <= '0;
      row_q  <= '0;
    end else begin
      if (cmd_i.accept) begin
        wp_q <= wp_d;
        if (!sts_o.lead_full) lead_q <= lead_q + 1'b1;
      end
      if (cmd_i.emit) begin
        if (last) begin
          lead_q <= '0;
          col_q  <= '0;
          row_q  <= '0;
        end else if ((WW + 1)'(col_q) + 1'b1 >= (WW + 1)'(w)) begin
          col_q <= '0;
          row_q <= row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
    end
  end

  // Newest row of the window: current pixel and the two before it
  logic [PB-1:0] cur_q, p1_q, p2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
      p1_q  <= '0;
      p2_q  <= '0;
    end else if (cmd_i.accept) begin
      cur_q <= pix;
      p1_q  <= cur_q;
      p2_q  <= p1_q;
    end
  end

  // Ring addresses one and two rows back
  logic [SW-1:0] w_ext, off_a, off_b, sum_a, sum_b;
  logic [AW-1:0] ra, rb;

  always_comb begin
    w_ext = SW'(w);
    off_a = w_ext + SW'(2) - SW'(cmd_i.rd_col);
    off_b = (w_ext << 1) + SW'(2) - SW'(cmd_i.rd_col);
    sum_a = SW'(wp_q) + SW'(RING) - off_a;
    sum_b = SW'(wp_q) + SW'(RING) - off_b;
    ra    = (sum_a >= SW'(RING)) ? AW'(sum_a - SW'(RING)) : AW'(sum_a);
    rb    = (sum_b >= SW'(RING)) ? AW'(sum_b - SW'(RING)) : AW'(sum_b);
  end

  // Pixel ring: one write, two registered reads
  logic [PB-1:0] ring_mem [RING];
  logic [PB-1:0] rda_q, rdb_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) ring_mem[wp_d] <= pix;
    if (cmd_i.rd_en) begin
      rda_q <= ring_mem[ra];
      rdb_q <= ring_mem[rb];
    end
  end

  // Capture the two older window rows
  logic [PB-1:0] r0_q [3];
  logic [PB-1:0] r1_q [3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_en) begin
      r1_q[cmd_i.cap_col] <= rda_q;
      r0_q[cmd_i.cap_col] <= rdb_q;
    end
  end

  // Border masks
  logic [2:0] rv, cv;

  always_comb begin
    rv[0] = (row_q != '0) && ((HW + 1)'(row_q) - 1'b1 < (HW + 1)'(h));
    rv[1] = row_q < h;
    rv[2] = (HW + 1)'(row_q) + 1'b1 < (HW + 1)'(h);
    cv[0] = (col_q != '0) && ((WW + 1)'(col_q) - 1'b1 < (WW + 1)'(w));
    cv[1] = col_q < w;
    cv[2] = (WW + 1)'(col_q) + 1'b1 < (WW + 1)'(w);
  end

  // Gradients per channel
  logic [PB-1:0]        win [3][3];
  logic [CB-1:0]        v   [3][3];
  logic [CB+1:0]        pos_x, neg_x, pos_y, neg_y;
  logic signed [GB-1:0] gx_d [3];
  logic signed [GB-1:0] gy_d [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win[0][k] = r0_q[k];
      win[1][k] = r1_q[k];
    end
    win[2][0] = p2_q;
    win[2][1] = p1_q;
    win[2][2] = cur_q;
    pos_x = '0;
    neg_x = '0;
    pos_y = '0;
    neg_y = '0;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          v[r][k] = (rv[r] && cv[k]) ? win[r][k][c*CB +: CB] : '0;
        end
      end
      pos_x = (CB + 2)'(v[0][2]) + ((CB + 2)'(v[1][2]) << 1) + (CB + 2)'(v[2][2]);
      neg_x = (CB + 2)'(v[0][0]) + ((CB + 2)'(v[1][0]) << 1) + (CB + 2)'(v[2][0]);
      pos_y = (CB + 2)'(v[2][0]) + ((CB + 2)'(v[2][1]) << 1) + (CB + 2)'(v[2][2]);
      neg_y = (CB + 2)'(v[0][0]) + ((CB + 2)'(v[0][1]) << 1) + (CB + 2)'(v[0][2]);
      gx_d[c] = $signed(GB'(pos_x)) - $signed(GB'(neg_x));
      gy_d[c] = $signed(GB'(pos_y)) - $signed(GB'(neg_y));
    end
  end

  // Gradient, power and root registers
  logic signed [GB-1:0]       gx_q [3];
  logic signed [GB-1:0]       gy_q [3];
  logic [QB-1:0]              pwr_q [3];
  logic [CB-1:0]              m_q [3];
  logic signed [2*GB-1:0]     sqx [3];
  logic signed [2*GB-1:0]     sqy [3];
  logic [CB-1:0]              trial [3];
  logic [2*CB:0]              prod [3];
  logic [CB:0]                mag [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sqx[c]   = gx_q[c] * gx_q[c];
      sqy[c]   = gy_q[c] * gy_q[c];
      trial[c] = m_q[c] | (CB'(1) << cmd_i.root_bit);
      prod[c]  = (2 * CB + 1)'(trial[c]) * ((2 * CB + 1)'(trial[c]) + 1'b1);
      if (pwr_q[c] > QB'(sem_pkg::PWR_CAP)) mag[c] = (CB + 1)'(sem_pkg::MAG_CAP);
      else if (pwr_q[c] == '0)              mag[c] = '0;
      else                                  mag[c] = (CB + 1)'(m_q[c]) + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      if (cmd_i.grad_en) begin
        gx_q[c] <= gx_d[c];
        gy_q[c] <= gy_d[c];
      end
      if (cmd_i.pwr_en) begin
        pwr_q[c] <= QB'($unsigned(sqx[c])) + QB'($unsigned(sqy[c]));
        m_q[c]   <= '0;
      end else if (cmd_i.root_en && (QB'(prod[c]) < pwr_q[c])) begin
        m_q[c] <= trial[c];
      end
    end
  end

  // Output register
  logic out_valid_q;

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      edge_red_o   <= CB'(mag[0]);
      edge_green_o <= CB'(mag[1]);
      edge_blue_o  <= CB'(mag[2]);
      last_pixel_o <= last;
    end
  end

endmodule

// ===== src/sem_checker.sv =====
// Port-level checks for the Sobel block, bound to the top level.
// Depends on sobel_edge_magnitude_rgb and its interface ports.
`timescale 1ns / 1ps

module sem_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [24:0] out_data_i
);

  // A result appears only after the input side was held off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared while input was open");

  // An accepted item never yields a result on the very next edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !$rose(out_valid_i))
    else $error("result too early after accept");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_data_i)))
    else $error("stalled result changed");

endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (edge_o.valid),
  .out_ready_i (edge_o.ready),
  .out_data_i  ({edge_o.last_pixel, edge_o.edge_blue, edge_o.edge_green, edge_o.edge_red})
);

// ===== tb/sv/sem_edge_checker.sv =====
// Scoreboard for the RGB Sobel edge block: watches the pixel, edge and register channels.
// It predicts each edge item from the accepted pixels and compares the edge items field by field.
// Depends on sem_pkg and the channel interfaces in sem_if.
`timescale 1ns / 1ps

module sem_edge_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  sem_pix_if    pix,
  sem_edge_if   edg,
  sem_cfg_if    cfg,
  output int    fail_count_o,
  output int    pending_o,
  output logic  frame_open_o
);
  import sem_pkg::*;

  localparam int unsigned RING = 2 * MAX_WIDTH_DEF + 3;

  typedef struct packed {
    logic [CHAN_BITS-1:0] r;
    logic [CHAN_BITS-1:0] g;
    logic [CHAN_BITS-1:0] b;
    logic                 last;
  } edge_item_t;

  logic [CFG_WIDTH_BITS-1:0]  width_reg;
  logic [CFG_HEIGHT_BITS-1:0] height_reg;
  logic [PIX_BITS-1:0]        ring [RING];
  int unsigned                wr_pos, lead_cnt, col_pos, row_pos;
  edge_item_t                 edge_q [$];
  int                         fails;

  assign fail_count_o = fails;
  assign pending_o    = edge_q.size();
  assign frame_open_o = (lead_cnt != 0);

  task automatic report(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    fails++;
  endtask

  function automatic int unsigned eff_dim(int unsigned v, int unsigned cap);
    if (v == 0) return 1;
    return (v > cap) ? cap : v;
  endfunction

  // Rounded root, capped: smallest n with n*(n+1) >= s
  function automatic logic [CHAN_BITS-1:0] rounded_root(int gx, int gy);
    int unsigned s, n;
    s = gx * gx + gy * gy;
    n = 0;
    if (s > PWR_CAP) return CHAN_BITS'(MAG_CAP);
    while (n * (n + 1) < s) n++;
    return n[CHAN_BITS-1:0];
  endfunction

  function automatic logic [CHAN_BITS-1:0] sobel_chan(int unsigned w, int unsigned h, int sh);
    int gx, gy, rr, cc, v, wx, wy;
    int unsigned off, idx;
    gx = 0;
    gy = 0;
    for (int kr = 0; kr < 3; kr++) begin
      for (int kc = 0; kc < 3; kc++) begin
        rr = int'(row_pos) + kr - 1;
        cc = int'(col_pos) + kc - 1;
        if (rr < 0 || cc < 0 || rr >= int'(h) || cc >= int'(w)) continue;
        off = (2 - kr) * w + (2 - kc);
        idx = (wr_pos + RING - off) % RING;
        v   = int'((ring[idx] >> sh) & 8'hFF);
        wx  = (kc - 1) * ((kr == 1) ? 2 : 1);
        wy  = (kr - 1) * ((kc == 1) ? 2 : 1);
        gx += v * wx;
        gy += v * wy;
      end
    end
    return rounded_root(gx, gy);
  endfunction

  // Advance the prediction by one accepted pixel item
  task automatic take_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic drain);
    int unsigned w, h;
    edge_item_t  e;
    w = eff_dim(width_reg, MAX_WIDTH_DEF);
    h = eff_dim(height_reg, MAX_HEIGHT_DEF);
    wr_pos = (wr_pos + 1) % RING;
    ring[wr_pos] = drain ? '0 : {b, g, r};
    if (lead_cnt < w + 1) begin
      lead_cnt++;
      return;
    end
    e.r    = sobel_chan(w, h, 0);
    e.g    = sobel_chan(w, h, 8);
    e.b    = sobel_chan(w, h, 16);
    e.last = (row_pos + 1 >= h) && (col_pos + 1 >= w);
    edge_q.push_back(e);
    if (e.last) begin
      lead_cnt = 0;
      col_pos  = 0;
      row_pos  = 0;
    end else begin
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
    end
  endtask

  // Watch all three channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    edge_item_t want;
    if (!rst_ni) begin
      width_reg  <= CFG_WIDTH_BITS'(RESET_WIDTH);
      height_reg <= CFG_HEIGHT_BITS'(RESET_HEIGHT);
      wr_pos     = 0;
      lead_cnt   = 0;
      col_pos    = 0;
      row_pos    = 0;
      edge_q.delete();
      for (int i = 0; i < RING; i++) ring[i] = '0;
    end else begin
      if (edg.valid && edg.ready) begin
        if (edge_q.size() == 0) begin
          report("unexpected edge item", edg.edge_red, -1);
        end else begin
          want = edge_q.pop_front();
          if (edg.edge_red !== want.r) report("edge_red", edg.edge_red, want.r);
          if (edg.edge_green !== want.g) report("edge_green", edg.edge_green, want.g);
          if (edg.edge_blue !== want.b) report("edge_blue", edg.edge_blue, want.b);
          if (edg.last_pixel !== want.last) report("last_pixel", edg.last_pixel, want.last);
        end
      end
      if (pix.valid && pix.ready) take_pixel(pix.red, pix.green, pix.blue, pix.drain);
      if (cfg.valid && cfg.ready) begin
        case (reg_idx_e'(cfg.index))
          REG_FRAME_WIDTH:  width_reg  <= cfg.data[CFG_WIDTH_BITS-1:0];
          REG_FRAME_HEIGHT: height_reg <= cfg.data[CFG_HEIGHT_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  initial fails = 0;

endmodule

// ===== tb/sv/tb_sobel_edge_magnitude_rgb.sv =====
// Top testbench for the RGB Sobel edge block: clock, reset, stimulus and verdict.
// Depends on sem_pkg, sem_if, the block itself and sem_edge_checker.
`timescale 1ns / 1ps

module tb_sobel_edge_magnitude_rgb;
  import sem_pkg::*;

  localparam int STALL_LIMIT = 3000;

  logic clk_i;
  logic rst_ni;
  int   fail_count, pending;
  logic frame_open;
  logic calm;
  int   random_items, sent_items, frames_sent, idle_cycles, stall_left;

  sem_pix_if  pix ();
  sem_edge_if edg ();
  sem_cfg_if  cfg ();

  sobel_edge_magnitude_rgb dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix.sink),
    .edge_o (edg.source),
    .cfg_i  (cfg.sink)
  );

  sem_edge_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix          (pix),
    .edg          (edg),
    .cfg          (cfg),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .frame_open_o (frame_open)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Drop edge ready in random bursts, unless calm
  always @(negedge clk_i) begin
    if (calm) begin
      edg.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      edg.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      edg.ready <= 1'b0;
    end else begin
      edg.ready <= 1'b1;
    end
  end

  // Watchdog: end the run after too many cycles without any accepted item
  always @(posedge clk_i) begin
    if ((pix.valid && pix.ready) || (edg.valid && edg.ready) || (cfg.valid && cfg.ready)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic drain);
    int gap;
    gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.red   <= r;
    pix.green <= g;
    pix.blue  <= b;
    pix.drain <= drain;
    do @(posedge clk_i); while (!pix.ready);
    sent_items++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CFG_DATA_BITS-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk_i); while (!cfg.ready);
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  // Pad any open frame with drain items, wait until every expected item is back, then let the block settle
  task automatic settle();
    pix.valid <= 1'b0;
    while (frame_open) send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
    pix.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_frame(int w, int h);
    settle();
    write_reg(REG_FRAME_WIDTH, CFG_DATA_BITS'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_BITS'(h));
  endtask

  // One frame: pattern 0 random, 1 all zero, 2 all max, 3 checkerboard.
  // Noise puts black drain items inside the frame and miscounts the trailing drains.
  task automatic send_frame(int w, int h, int pattern, bit noisy);
    int   ntail;
    logic [7:0] r, g, b;
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        case (pattern)
          1: {r, g, b} = '0;
          2: {r, g, b} = '1;
          3: {r, g, b} = ((x + y) % 2) ? 24'hFFFFFF : 24'h000000;
          default: {r, g, b} = 24'($urandom);
        endcase
        send_pixel(r, g, b, noisy && $urandom_range(0, 9) == 0);
        if (pattern == 0) random_items++;
      end
    end
    ntail = w + 1;
    if (noisy && $urandom_range(0, 3) == 0) ntail = ntail + $urandom_range(0, 3) - 2;
    for (int i = 0; i < ntail; i++) begin
      // drain flag cleared now and then: a pixel item past the frame end is ignored
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                 !(noisy && $urandom_range(0, 4) == 0));
    end
    frames_sent++;
  endtask

  initial begin
    int w, h;
    calm         = 1'b0;
    random_items = 0;
    sent_items   = 0;
    frames_sent  = 0;
    idle_cycles  = 0;
    stall_left   = 0;
    pix.valid    = 1'b0;
    pix.red      = '0;
    pix.green    = '0;
    pix.blue     = '0;
    pix.drain    = 1'b0;
    edg.ready    = 1'b1;
    cfg.valid    = 1'b0;
    cfg.index    = REG_FRAME_WIDTH;
    cfg.data     = '0;
    rst_ni       = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: flat and maximal contrast frames, stray pixels after a frame end
    set_frame(3, 3);
    send_frame(3, 3, 1, 1'b0);
    send_frame(3, 3, 2, 1'b0);
    send_frame(3, 3, 3, 1'b0);
    send_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
    send_pixel(8'h00, 8'hFF, 8'h00, 1'b1);
    send_frame(3, 3, 2, 1'b0);
    // Zero sizes act as one pixel
    set_frame(0, 0);
    send_frame(1, 1, 2, 1'b0);

    // Random frames, mostly well formed, some with noise
    while (sent_items < 850) begin
      w = $urandom_range(1, 10);
      h = $urandom_range(1, 6);
      set_frame(w, h);
      repeat ($urandom_range(1, 2)) send_frame(w, h, 0, $urandom_range(0, 3) == 0);
    end

    // Closing stretch without any idling
    set_frame(5, 4);
    calm = 1'b1;
    send_frame(5, 4, 0, 1'b0);
    send_frame(5, 4, 0, 1'b0);
    settle();

    $display("covered %0d frames, %0d pixel items (%0d random), sizes 1x1 to 10x6",
             frames_sent, sent_items, random_items);
    $display("with zero sizes, drains inside frames and stray pixels after frame end");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sem_pkg.sv
src/sem_if.sv
src/sem_ctrl.sv
src/sem_datapath.sv
src/sobel_edge_magnitude_rgb.sv
src/sem_checker.sv
tb/sv/sem_edge_checker.sv
tb/sv/tb_sobel_edge_magnitude_rgb.sv
